@@ src/gtb_pkg.sv @@
// Shared types and constants for the glyph text blitter.
// Used by gtb_front, gtb_queue, gtb_back and glyph_text_blitter_top.
`timescale 1ns / 1ps

package gtb_pkg;

   // input item kinds (req_tuser)
   localparam logic [1:0] OP_CHAR      = 2'd0;
   localparam logic [1:0] OP_SAMPLE    = 2'd1;
   localparam logic [1:0] OP_PEN_RESET = 2'd2;

   // character codes with special meaning
   localparam logic [20:0] CODE_TAB     = 21'd9;
   localparam logic [20:0] CODE_NEWLINE = 21'd10;
   localparam logic [20:0] CODE_CR      = 21'd13;
   localparam logic [20:0] CODE_SPACE   = 21'd32;

   localparam logic [7:0]  MIN_INK_ALPHA = 8'd16;
   localparam logic [15:0] PIXEL_OPAQUE  = 16'h8000;

   // register indexes on the csr port
   localparam logic [2:0] REG_MARGIN_LEFT    = 3'd0;
   localparam logic [2:0] REG_MARGIN_TOP     = 3'd1;
   localparam logic [2:0] REG_MARGIN_RIGHT   = 3'd2;
   localparam logic [2:0] REG_MARGIN_BOTTOM  = 3'd3;
   localparam logic [2:0] REG_LINE_ADVANCE   = 3'd4;
   localparam logic [2:0] REG_FIRST_BASELINE = 3'd5;
   localparam logic [2:0] REG_TEXT_COLOR     = 3'd6;

   localparam logic [7:0]  RST_LINE_ADVANCE   = 8'd16;
   localparam logic [8:0]  RST_FIRST_BASELINE = 9'd12;
   localparam logic [14:0] RST_TEXT_COLOR     = 15'h7FFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CMD_NOP       = 3'd0,
      CMD_NEWLINE   = 3'd1,
      CMD_PRINT     = 3'd2,
      CMD_SAMPLE    = 3'd3,
      CMD_PEN_RESET = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         visible;      // printable glyph that opens a box
      logic [7:0]   advance;
      logic [7:0]   bearing_left;
      logic [7:0]   bearing_top;
      logic [7:0]   glyph_width;
      logic [7:0]   glyph_height;
      logic [7:0]   sample_alpha;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  margin_left;
      logic [7:0]  margin_top;
      logic [7:0]  margin_right;
      logic [7:0]  margin_bottom;
      logic [7:0]  line_advance;
      logic [8:0]  first_baseline;
      logic [14:0] text_color;
   } csr_type;

endpackage

@@ src/glyph_text_blitter_top.sv @@
// Glyph text blitter: top level with the csr register file.
// Depends on gtb_pkg, gtb_front, gtb_queue and gtb_back.
//
// Usage: items enter on req_* (req_tuser = opcode: character, alpha sample,
// pen reset; req_tdata = character and glyph fields). Every item yields
// exactly one result item on rsp_* carrying an optional pixel write plus
// the pen position after the item; rsp_tuser flags a pixel write and a
// dropped, wrapped character.
// An accepted item is first written into the command queue; the back end then
// pops it into the result register. Throughput: one item per cycle while
// rsp_tready is high, with a combinational pen/clip/address update in the back end.
// A 4-entry command queue sits between front and back, so req_tready only
// drops when the queue is full, i.e. after the result side has stalled;
// the result register holds its item until rsp_tready.
// Reset (synchronous, active high) empties the queue, drops any pending
// result, closes the glyph box and loads register reset values; the pen
// starts at column 0, row 12. The user must write registers on csr_* only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module glyph_text_blitter_top #(
   parameter int BUF_WIDTH  = 256,
   parameter int BUF_HEIGHT = 192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   // char_code[20:0], printable[21], has_glyph[22], advance[30:23],
   // bearing_left[38:31], bearing_top[46:39], glyph_width[54:47],
   // glyph_height[62:55], sample_alpha[70:63], zero[71]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // write_enable[0], wrapped[1]
   output logic [1:0]  rsp_tuser,
   // pixel_address[15:0], pixel_value[31:16], alpha_value[39:32],
   // pen_column[55:40], pen_row[71:56]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [14:0] csr_wdata
);
   import gtb_pkg::*;

   csr_type csr_ff;
   cmd_type front_cmd, back_cmd;
   logic    push, pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.margin_left    <= '0;
         csr_ff.margin_top     <= '0;
         csr_ff.margin_right   <= '0;
         csr_ff.margin_bottom  <= '0;
         csr_ff.line_advance   <= RST_LINE_ADVANCE;
         csr_ff.first_baseline <= RST_FIRST_BASELINE;
         csr_ff.text_color     <= RST_TEXT_COLOR;
      end else if (csr_we) begin
         case (csr_addr)
            REG_MARGIN_LEFT:    csr_ff.margin_left    <= csr_wdata[7:0];
            REG_MARGIN_TOP:     csr_ff.margin_top     <= csr_wdata[7:0];
            REG_MARGIN_RIGHT:   csr_ff.margin_right   <= csr_wdata[7:0];
            REG_MARGIN_BOTTOM:  csr_ff.margin_bottom  <= csr_wdata[7:0];
            REG_LINE_ADVANCE:   csr_ff.line_advance   <= csr_wdata[7:0];
            REG_FIRST_BASELINE: csr_ff.first_baseline <= csr_wdata[8:0];
            REG_TEXT_COLOR:     csr_ff.text_color     <= csr_wdata;
            default: ;
         endcase
      end
   end

   gtb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .cmd        (front_cmd)
   );

   gtb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .pop_cmd  (back_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   gtb_back #(
      .BUF_WIDTH  (BUF_WIDTH),
      .BUF_HEIGHT (BUF_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .q_empty    (q_empty),
      .cmd        (back_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ src/gtb_front.sv @@
// Front end: takes request items and classifies them into commands.
// Depends on gtb_pkg.
`timescale 1ns / 1ps

module gtb_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   input  logic [71:0]       req_tdata,
   input  logic              q_full,
   output logic              push,
   output gtb_pkg::cmd_type  cmd
);
   import gtb_pkg::*;

   logic [20:0] char_code;
   logic        printable;
   logic        has_glyph;
   logic        invisible;

   assign char_code = req_tdata[20:0];
   assign printable = req_tdata[21];
   assign has_glyph = req_tdata[22];
   assign invisible = char_code inside {CODE_SPACE, CODE_TAB, CODE_CR};

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      cmd.advance      = req_tdata[30:23];
      cmd.bearing_left = req_tdata[38:31];
      cmd.bearing_top  = req_tdata[46:39];
      cmd.glyph_width  = req_tdata[54:47];
      cmd.glyph_height = req_tdata[62:55];
      cmd.sample_alpha = req_tdata[70:63];
      cmd.visible      = !invisible && has_glyph &&
                         (cmd.glyph_width != 8'd0) && (cmd.glyph_height != 8'd0);
      case (req_tuser)
         OP_CHAR: begin
            // newline wins regardless of the printable flag
            if (char_code == CODE_NEWLINE) cmd.kind = CMD_NEWLINE;
            else if (printable)            cmd.kind = CMD_PRINT;
            else                           cmd.kind = CMD_NOP;
         end
         OP_SAMPLE:    cmd.kind = CMD_SAMPLE;
         OP_PEN_RESET: cmd.kind = CMD_PEN_RESET;
         default:      cmd.kind = CMD_NOP;
      endcase
   end

endmodule

@@ src/gtb_queue.sv @@
// Short command queue between front end and back end.
// Depends on gtb_pkg.
`timescale 1ns / 1ps

module gtb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gtb_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output gtb_pkg::cmd_type  pop_cmd,
   output logic              full,
   output logic              empty
);
   import gtb_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

@@ src/gtb_back.sv @@
// Back end: pen and glyph box state, clipping, address generation and
// the registered result stage. Depends on gtb_pkg.
`timescale 1ns / 1ps

module gtb_back #(
   parameter int BUF_WIDTH  = 256,
   parameter int BUF_HEIGHT = 192
) (
   input  logic              clock,
   input  logic              reset,
   input  gtb_pkg::csr_type  csr,
   input  logic              q_empty,
   input  gtb_pkg::cmd_type  cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        rsp_tuser,
   output logic [71:0]       rsp_tdata
);
   import gtb_pkg::*;

   localparam logic [15:0] BW16 = 16'(BUF_WIDTH);

   // architectural state
   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic [15:0] origin_x_ff, origin_x_in;
   logic [15:0] origin_y_ff, origin_y_in;
   logic [7:0]  box_w_ff, box_w_in;
   logic [7:0]  box_h_ff, box_h_in;
   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic        active_ff, active_in;

   // result register
   logic        rsp_valid_ff;
   logic        we_ff, we_in;
   logic        wrapped_ff, wrapped_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] pix_ff, pix_in;
   logic [7:0]  alpha_ff, alpha_in;

   logic [17:0] wrap_sum, right_lim, bottom_lim, px, py;
   logic [31:0] row_base;
   logic        wrap, inside_box;

   assign pop = !q_empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      wrap_sum   = {{2{pen_x_ff[15]}}, pen_x_ff} + {10'b0, cmd.advance};
      right_lim  = 18'(BUF_WIDTH) - {10'b0, csr.margin_right};
      bottom_lim = 18'(BUF_HEIGHT) - {10'b0, csr.margin_bottom};
      wrap       = $signed(wrap_sum) >= $signed(right_lim);
      px         = {{2{origin_x_ff[15]}}, origin_x_ff} + {10'b0, col_ff};
      py         = {{2{origin_y_ff[15]}}, origin_y_ff} + {10'b0, row_ff};
      inside_box = ($signed(px) >= $signed({10'b0, csr.margin_left})) &&
                   ($signed(px) <  $signed(right_lim)) &&
                   ($signed(py) >= $signed({10'b0, csr.margin_top})) &&
                   ($signed(py) <  $signed(bottom_lim)) &&
                   (cmd.sample_alpha >= MIN_INK_ALPHA);
      row_base   = {16'b0, py[15:0]} * {16'b0, BW16};

      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      box_w_in    = box_w_ff;
      box_h_in    = box_h_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      active_in   = active_ff;
      we_in       = 1'b0;
      wrapped_in  = 1'b0;
      addr_in     = '0;
      pix_in      = '0;
      alpha_in    = '0;

      case (cmd.kind)
         CMD_NEWLINE: begin
            active_in = 1'b0;
            pen_x_in  = {8'b0, csr.margin_left};
            pen_y_in  = pen_y_ff + {8'b0, csr.line_advance};
         end
         CMD_PRINT: begin
            active_in = 1'b0;
            if (wrap) begin
               // character is dropped, pen goes to the next line
               pen_x_in   = {8'b0, csr.margin_left};
               pen_y_in   = pen_y_ff + {8'b0, csr.line_advance};
               wrapped_in = 1'b1;
            end else begin
               if (cmd.visible) begin
                  origin_x_in = pen_x_ff + {{8{cmd.bearing_left[7]}}, cmd.bearing_left};
                  origin_y_in = pen_y_ff - {{8{cmd.bearing_top[7]}}, cmd.bearing_top};
                  box_w_in    = cmd.glyph_width;
                  box_h_in    = cmd.glyph_height;
                  col_in      = '0;
                  row_in      = '0;
                  active_in   = 1'b1;
               end
               pen_x_in = wrap_sum[15:0];
            end
         end
         CMD_SAMPLE: begin
            if (active_ff) begin
               if (inside_box) begin
                  we_in    = 1'b1;
                  addr_in  = row_base[15:0] + px[15:0];
                  pix_in   = PIXEL_OPAQUE | {1'b0, csr.text_color};
                  alpha_in = cmd.sample_alpha;
               end
               if ({1'b0, col_ff} + 9'd1 >= {1'b0, box_w_ff}) begin
                  col_in = '0;
                  if ({1'b0, row_ff} + 9'd1 >= {1'b0, box_h_ff}) active_in = 1'b0;
                  else                                         row_in = row_ff + 8'd1;
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
         CMD_PEN_RESET: begin
            pen_x_in = {8'b0, csr.margin_left};
            pen_y_in = {7'b0, csr.first_baseline};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= {7'b0, RST_FIRST_BASELINE};
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         box_w_ff     <= '0;
         box_h_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pen_x_ff    <= pen_x_in;
            pen_y_ff    <= pen_y_in;
            origin_x_ff <= origin_x_in;
            origin_y_ff <= origin_y_in;
            box_w_ff    <= box_w_in;
            box_h_ff    <= box_h_in;
            col_ff      <= col_in;
            row_ff      <= row_in;
            active_ff   <= active_in;
         end
         if (pop)             rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         we_ff      <= we_in;
         wrapped_ff <= wrapped_in;
         addr_ff    <= addr_in;
         pix_ff     <= pix_in;
         alpha_ff   <= alpha_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {wrapped_ff, we_ff};
   // pen fields read the state register, which is updated with the result
   assign rsp_tdata  = {pen_y_ff, pen_x_ff, alpha_ff, pix_ff, addr_ff};

endmodule
